/* design/jfps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_pkg
// shared constants for the four-point jacobi stencil: default sizes, field
// widths, register indexes and configuration reset values
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 18;

    localparam int GW_BITS  = 11;
    localparam int GH_BITS  = 16;
    localparam int ROW_BITS = 16;
    localparam int COL_BITS = 10;
    localparam int ERR_BITS = 18;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'd1;

    localparam logic [GW_BITS-1:0] GRID_WIDTH_RST  = 11'd512;
    localparam logic [GH_BITS-1:0] GRID_HEIGHT_RST = 16'd512;

endpackage
`default_nettype wire

/* design/jfps_line_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_line_buf
// one row buffer: single write port, single registered read port,
// read-first when both ports hit the same entry
// ----------------------------------------------------------------------------
module jfps_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 18,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* design/jacobi_four_point_stencil.sv */
`default_nettype none
// path: a sample is registered in p1, p2 and p3, then in the output register
// throughput: one sample per cycle without output stall or realign, set by one read of each row buffer per cycle
// after the width is shrunk below the current column, RA_READ0, RA_READ1 and RA_SHIFT reload the row window
// reset: counters, running maximum, bank select and valids clear; row buffers are not
// cleared and take no clearing pass
// ----------------------------------------------------------------------------
// jacobi_four_point_stencil
// streaming four-neighbour average over a raster grid with two line buffers,
// row/column tagging, last flag and running maximum of the change
// ----------------------------------------------------------------------------
module jacobi_four_point_stencil #(
    parameter int MAX_WIDTH   = jfps_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = jfps_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [jfps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [jfps_pkg::CFG_DATA_BITS-1:0] cfg_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  wire logic                               s_grid_start,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]           m_new_value,
    output logic [jfps_pkg::ROW_BITS-1:0]           m_out_row,
    output logic [jfps_pkg::COL_BITS-1:0]           m_out_col,
    output logic [jfps_pkg::ERR_BITS-1:0]           m_max_error,
    output logic                                    m_last
);

    import jfps_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SB = SAMPLE_BITS;

    localparam logic [1:0] RA_IDLE  = 2'd0;
    localparam logic [1:0] RA_READ0 = 2'd1;
    localparam logic [1:0] RA_READ1 = 2'd2;
    localparam logic [1:0] RA_SHIFT = 2'd3;

    // configuration
    logic [GW_BITS-1:0]  grid_width_reg;
    logic [GH_BITS-1:0]  grid_height_reg;
    logic                cfg_wr;

    // counters and stream state
    logic [CW-1:0]       col_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;
    logic                bank_sel_reg;
    logic [SB-1:0]       prev_sample_reg;
    logic [SB-1:0]       running_max_reg;

    // effective sizes and current position
    logic [CW-1:0]       wlast;
    logic [ROW_BITS-1:0] hlast;
    logic [CW-1:0]       cnt_c;
    logic [ROW_BITS-1:0] cnt_r;
    logic                acc_sel;
    logic [CW-1:0]       col_cur;
    logic [ROW_BITS-1:0] row_cur;
    logic [CW-1:0]       col_m1;
    logic                row_end;
    logic                s_accept;

    // deferred write of the row's final sample
    logic                pend_valid_reg;
    logic                pend_bank_reg;
    logic [CW-1:0]       pend_addr_reg;

    // window realign after a width shrink
    logic [1:0]          ra_state_reg;
    logic [1:0]          ra_state_next;
    logic                aligned_reg;
    logic                realign_need;
    logic                ra_read;
    logic [CW-1:0]       ra_addr;

    // row buffers
    logic                rd_en;
    logic [CW-1:0]       rd_addr0;
    logic [CW-1:0]       rd_addr1;
    logic [SB-1:0]       rd_data0;
    logic [SB-1:0]       rd_data1;
    logic                rd_sel_reg;
    logic [SB-1:0]       rd_mid;
    logic [SB-1:0]       rd_up;
    logic                wr_en0;
    logic                wr_en1;
    logic [CW-1:0]       wr_addr0;
    logic [CW-1:0]       wr_addr1;
    logic                col_wr;

    // window of the middle row
    logic [SB-1:0]       win1_reg;
    logic [SB-1:0]       win2_reg;
    logic                win_shift;

    // pipeline
    logic                out_free;
    logic                free1;
    logic                free2;
    logic                free3;

    logic                v1_reg;
    logic                emit1_reg;
    logic                last1_reg;
    logic                start1_reg;
    logic [ROW_BITS-1:0] row1_reg;
    logic [COL_BITS-1:0] col1_reg;
    logic [SB-1:0]       down1_reg;

    logic                v2_reg;
    logic                emit2_reg;
    logic                last2_reg;
    logic                start2_reg;
    logic [ROW_BITS-1:0] row2_reg;
    logic [COL_BITS-1:0] col2_reg;
    logic [SB-1:0]       nv2_reg;
    logic [SB-1:0]       center2_reg;

    logic                v3_reg;
    logic                emit3_reg;
    logic                last3_reg;
    logic                start3_reg;
    logic [ROW_BITS-1:0] row3_reg;
    logic [COL_BITS-1:0] col3_reg;
    logic [SB-1:0]       nv3_reg;
    logic [SB-1:0]       ad3_reg;

    logic [SB+1:0]       sum1;
    logic [SB-1:0]       nv1;
    logic [SB:0]         diff2;
    logic [SB:0]         diff2_abs;
    logic [SB-1:0]       ad2;
    logic [SB-1:0]       max_base;
    logic [SB-1:0]       max_new;

    logic                m_valid_reg;
    logic [SB-1:0]       m_new_value_reg;
    logic [ROW_BITS-1:0] m_out_row_reg;
    logic [COL_BITS-1:0] m_out_col_reg;
    logic [ERR_BITS-1:0] m_max_error_reg;
    logic                m_last_reg;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GW_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamped last column and last row
    always_comb begin
        if (grid_width_reg < GW_BITS'(3)) begin
            wlast = CW'(2);
        end else if (32'(grid_width_reg) > 32'(MAX_WIDTH)) begin
            wlast = CW'(MAX_WIDTH - 1);
        end else begin
            wlast = CW'(grid_width_reg - GW_BITS'(1));
        end
        if (grid_height_reg < GH_BITS'(3)) begin
            hlast = ROW_BITS'(2);
        end else begin
            hlast = grid_height_reg - GH_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // current position of the incoming sample
    // ------------------------------------------------------------------
    always_comb begin
        cnt_c   = s_grid_start ? '0 : col_count_reg;
        cnt_r   = s_grid_start ? '0 : row_count_reg;
        acc_sel = s_grid_start ? 1'b0 : bank_sel_reg;
        col_cur = (cnt_c > wlast) ? wlast : cnt_c;
        row_cur = (cnt_r > hlast) ? hlast : cnt_r;
        col_m1  = col_cur - CW'(1);
        row_end = (col_cur == wlast);
    end

    assign realign_need = (col_count_reg > wlast) && !aligned_reg;
    assign s_ready      = free1 && (ra_state_reg == RA_IDLE) && !realign_need;
    assign s_accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            bank_sel_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= s_accept && row_end;
            if (s_accept) begin
                if (row_end) begin
                    col_count_reg <= '0;
                    bank_sel_reg  <= ~acc_sel;
                    row_count_reg <= (row_cur >= hlast) ? '0 : row_cur + ROW_BITS'(1);
                end else begin
                    col_count_reg <= col_cur + CW'(1);
                    bank_sel_reg  <= acc_sel;
                    row_count_reg <= row_cur;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= '0;
        end else if (s_accept) begin
            prev_sample_reg <= s_sample;
        end
    end

    // final sample of a row goes in during the next cycle, whose transfer is column zero
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_bank_reg <= acc_sel;
            pend_addr_reg <= col_cur;
        end
    end

    // ------------------------------------------------------------------
    // realign: reload the window at the clamped column
    // ------------------------------------------------------------------
    always_comb begin
        ra_state_next = ra_state_reg;
        case (ra_state_reg)
            RA_IDLE: begin
                if (realign_need && !v1_reg) begin
                    ra_state_next = RA_READ0;
                end
            end
            RA_READ0: ra_state_next = RA_READ1;
            RA_READ1: ra_state_next = RA_SHIFT;
            RA_SHIFT: ra_state_next = RA_IDLE;
            default:  ra_state_next = RA_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ra_state_reg <= RA_IDLE;
            aligned_reg  <= 1'b0;
        end else begin
            ra_state_reg <= ra_state_next;
            if (cfg_wr || s_accept) begin
                aligned_reg <= 1'b0;
            end else if (ra_state_reg == RA_SHIFT) begin
                aligned_reg <= 1'b1;
            end
        end
    end

    assign ra_read = (ra_state_reg == RA_READ0) || (ra_state_reg == RA_READ1);
    assign ra_addr = (ra_state_reg == RA_READ0) ? wlast - CW'(2) : wlast - CW'(1);

    // ------------------------------------------------------------------
    // row buffers: bank acc_sel is the upper row and takes the current row
    // ------------------------------------------------------------------
    assign rd_en  = s_accept || ra_read;
    assign col_wr = s_accept && (col_cur != '0);

    always_comb begin
        if (ra_read) begin
            rd_addr0 = ra_addr;
            rd_addr1 = ra_addr;
        end else begin
            rd_addr0 = (acc_sel == 1'b0) ? ((col_cur != '0) ? col_m1 : '0) : col_cur;
            rd_addr1 = (acc_sel == 1'b1) ? ((col_cur != '0) ? col_m1 : '0) : col_cur;
        end

        wr_en0   = 1'b0;
        wr_en1   = 1'b0;
        wr_addr0 = pend_addr_reg;
        wr_addr1 = pend_addr_reg;
        if (col_wr) begin
            if (acc_sel == 1'b0) begin
                wr_en0   = 1'b1;
                wr_addr0 = col_m1;
            end else begin
                wr_en1   = 1'b1;
                wr_addr1 = col_m1;
            end
        end else if (pend_valid_reg) begin
            if (pend_bank_reg == 1'b0) begin
                wr_en0 = 1'b1;
            end else begin
                wr_en1 = 1'b1;
            end
        end
    end

    jfps_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (SB)
    ) u_buf0 (
        .aclk    (aclk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr0),
        .wr_data (prev_sample_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr0),
        .rd_data (rd_data0)
    );

    jfps_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (SB)
    ) u_buf1 (
        .aclk    (aclk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr1),
        .wr_data (prev_sample_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr1),
        .rd_data (rd_data1)
    );

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_sel_reg <= s_accept ? acc_sel : bank_sel_reg;
        end
    end

    assign rd_mid = rd_sel_reg ? rd_data0 : rd_data1;
    assign rd_up  = rd_sel_reg ? rd_data1 : rd_data0;

    // ------------------------------------------------------------------
    // pipeline: p1 reads buffers, p2 holds the average, p3 the change
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign free3    = !v3_reg || out_free;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;

    assign win_shift = (v1_reg && free2) || (ra_state_reg == RA_READ1)
                    || (ra_state_reg == RA_SHIFT);

    always_ff @(posedge aclk) begin
        if (win_shift) begin
            win1_reg <= rd_mid;
            win2_reg <= win1_reg;
        end
    end

    always_comb begin
        sum1 = {{2{rd_mid[SB-1]}}, rd_mid} + {{2{win2_reg[SB-1]}}, win2_reg}
             + {{2{rd_up[SB-1]}}, rd_up} + {{2{down1_reg[SB-1]}}, down1_reg};
        nv1  = sum1[SB+1:2];

        diff2     = {nv2_reg[SB-1], nv2_reg} - {center2_reg[SB-1], center2_reg};
        diff2_abs = diff2[SB] ? -diff2 : diff2;
        ad2       = diff2_abs[SB-1:0];

        max_base = start3_reg ? '0 : running_max_reg;
        max_new  = (ad3_reg > max_base) ? ad3_reg : max_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (free1) begin
                v1_reg <= s_accept;
            end
            if (free2) begin
                v2_reg <= v1_reg;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            emit1_reg  <= (row_cur >= ROW_BITS'(2)) && (col_cur >= CW'(2));
            last1_reg  <= (row_cur == hlast) && row_end;
            start1_reg <= s_grid_start;
            row1_reg   <= row_cur - ROW_BITS'(1);
            col1_reg   <= COL_BITS'(col_m1);
            down1_reg  <= prev_sample_reg;
        end
        if (v1_reg && free2) begin
            emit2_reg   <= emit1_reg;
            last2_reg   <= last1_reg;
            start2_reg  <= start1_reg;
            row2_reg    <= row1_reg;
            col2_reg    <= col1_reg;
            nv2_reg     <= nv1;
            center2_reg <= win1_reg;
        end
        if (v2_reg && free3) begin
            emit3_reg  <= emit2_reg;
            last3_reg  <= last2_reg;
            start3_reg <= start2_reg;
            row3_reg   <= row2_reg;
            col3_reg   <= col2_reg;
            nv3_reg    <= nv2_reg;
            ad3_reg    <= ad2;
        end
    end

    // ------------------------------------------------------------------
    // output register and running maximum
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            running_max_reg <= '0;
        end else if (out_free) begin
            m_valid_reg <= v3_reg && emit3_reg;
            if (v3_reg) begin
                // border points still pass through so a grid start clears the maximum
                running_max_reg <= emit3_reg ? max_new : max_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && v3_reg) begin
            m_new_value_reg <= nv3_reg;
            m_out_row_reg   <= row3_reg;
            m_out_col_reg   <= col3_reg;
            m_max_error_reg <= ERR_BITS'(max_new);
            m_last_reg      <= last3_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_value = m_new_value_reg;
    assign m_out_row   = m_out_row_reg;
    assign m_out_col   = m_out_col_reg;
    assign m_max_error = m_max_error_reg;
    assign m_last      = m_last_reg;

`ifndef SYNTHESIS
    // realign owns the read ports, so no transfer may start meanwhile
    a_no_accept_in_realign: assert property (@(posedge aclk) disable iff (!aresetn)
        (ra_state_reg != RA_IDLE) |-> !s_ready)
        else $error("sample transfer allowed during window realign");

    // the deferred row-end write must never collide with a column write
    a_pend_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !col_wr)
        else $error("row-end write collides with column write");

    // buffer read data must hold while p1 is stalled
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !free2) |=> $stable(rd_mid) && $stable(rd_up))
        else $error("row buffer data lost under stall");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-point jacobi stencil. A short table of
// small grids, with the extremes typed in, comes first. Random grids follow
// under three idling mixes, with size changes between grids and in mid-grid,
// clamped size registers, a long output stall and one full-width grid. Every
// interior point is checked field by field against a line-buffer predictor.
// ----------------------------------------------------------------------------
module tb;
    import jfps_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 50;

    localparam logic signed [SB-1:0] SMAX = (2 ** (SB - 1)) - 1;
    localparam logic signed [SB-1:0] SMIN = -(2 ** (SB - 1));
    localparam logic [ERR_BITS-1:0]  ERR_MAX = '1;

    typedef struct {
        logic signed [SB-1:0] value;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [ERR_BITS-1:0]  err;
        logic                 last;
    } stencil_pt_t;

    typedef struct {
        logic signed [SB-1:0] smp;
        bit                   start;
        bit                   pinned;
        logic signed [SB-1:0] want_value;
        logic [ERR_BITS-1:0]  want_err;
    } plan_row_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [SB-1:0] s_sample = '0;
    logic                 s_grid_start = 1'b0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SB-1:0] m_new_value;
    logic [ROW_BITS-1:0]  m_out_row;
    logic [COL_BITS-1:0]  m_out_col;
    logic [ERR_BITS-1:0]  m_max_error;
    logic                 m_last;

    // typed expectation that travels with a directed sample
    logic                 pin_on = 1'b0;
    logic signed [SB-1:0] pin_value = '0;
    logic [ERR_BITS-1:0]  pin_err = '0;

    // predictor state
    int line_buf [2][MAX_W];
    int cur_row = 0;
    int cur_col = 0;
    int peak_change = 0;
    int bank = 0;
    int prev_smp = 0;
    int width_reg = int'(GRID_WIDTH_RST);
    int height_reg = int'(GRID_HEIGHT_RST);

    stencil_pt_t pending_points [$];
    plan_row_t   warmup_plan [27];

    int mismatches = 0;
    int samples_in = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    jacobi_four_point_stencil u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_grid_start(s_grid_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_value (m_new_value),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_max_error (m_max_error),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string note);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch: %s", note);
    endtask

    // one sample in, at most one interior point out
    function automatic bit relax_step(input logic signed [SB-1:0] smp, input bit start,
                                      output stencil_pt_t pt);
        int w, h, r, c, up, mid, sum, nv, d;
        bit hit;
        hit = 1'b0;
        pt = '{default: '0};
        if (start) begin
            cur_row = 0;
            cur_col = 0;
            peak_change = 0;
            bank = 0;
        end
        w = (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : width_reg;
        h = (height_reg < 3) ? 3 : height_reg;
        r = (cur_row > h - 1) ? h - 1 : cur_row;
        c = (cur_col > w - 1) ? w - 1 : cur_col;
        up = bank;
        mid = 1 - bank;
        if (r >= 2 && c >= 2) begin
            sum = line_buf[mid][c] + line_buf[mid][c-2] + line_buf[up][c-1] + prev_smp;
            nv = sum >>> 2;
            d = nv - line_buf[mid][c-1];
            if (d < 0)
                d = -d;
            if (d > peak_change)
                peak_change = d;
            pt.value = nv[SB-1:0];
            pt.row = ROW_BITS'(r - 1);
            pt.col = COL_BITS'(c - 1);
            pt.err = ERR_BITS'(peak_change);
            pt.last = (r == h - 1) && (c == w - 1);
            hit = 1'b1;
        end
        // current row goes one column behind into the bank read as the upper row
        if (c >= 1)
            line_buf[up][c-1] = prev_smp;
        if (c == w - 1)
            line_buf[up][c] = smp;
        prev_smp = smp;
        if (c == w - 1) begin
            c = 0;
            bank = 1 - bank;
            r = (r >= h - 1) ? 0 : r + 1;
        end else begin
            c++;
        end
        cur_row = r;
        cur_col = c;
        return hit;
    endfunction

    // output check, input prediction, register tracking and watchdog
    always @(posedge aclk) begin
        stencil_pt_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_points.size() == 0) begin
                    report_mismatch($sformatf("result (%0d,%0d) with nothing pending",
                                              m_out_row, m_out_col));
                end else begin
                    want = pending_points.pop_front();
                    if (m_new_value !== want.value)
                        report_mismatch($sformatf("new_value %0d, want %0d at (%0d,%0d)",
                                                  m_new_value, want.value, want.row, want.col));
                    if (m_out_row !== want.row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  m_out_row, want.row));
                    if (m_out_col !== want.col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  m_out_col, want.col));
                    if (m_max_error !== want.err)
                        report_mismatch($sformatf("max_error %0d, want %0d at (%0d,%0d)",
                                                  m_max_error, want.err, want.row, want.col));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b at (%0d,%0d)",
                                                  m_last, want.last, want.row, want.col));
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                if (cfg_index == REG_GRID_WIDTH)
                    width_reg = int'(cfg_data[GW_BITS-1:0]);
                else
                    height_reg = int'(cfg_data[GH_BITS-1:0]);
            end
            if (s_valid && s_ready) begin
                samples_in++;
                if (relax_step(s_sample, s_grid_start, want)) begin
                    if (pin_on) begin
                        want.value = pin_value;
                        want.err = pin_err;
                    end
                    pending_points.push_back(want);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_sample(input logic signed [SB-1:0] smp, input bit start,
                               input bit pinned, input logic signed [SB-1:0] pv,
                               input logic [ERR_BITS-1:0] pe);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_grid_start <= start;
        pin_on <= pinned;
        pin_value <= pv;
        pin_err <= pe;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic wait_for_results();
        while (pending_points.size() != 0)
            @(posedge aclk);
        // samples that make no point may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_grid_size(input logic [CFG_DATA_BITS-1:0] w_data,
                                  input logic [CFG_DATA_BITS-1:0] h_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= w_data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_data <= h_data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // keep_going continues the open grid under the new size (width never grows then)
    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] w_data,
                             input logic [CFG_DATA_BITS-1:0] h_data,
                             input int n_items, input bit keep_going, input bit squeeze);
        int w, h, span, pos;
        bit start;
        logic signed [SB-1:0] smp;
        wait_for_results();
        load_grid_size(w_data, h_data);
        w = int'(w_data[GW_BITS-1:0]);
        w = (w < 3) ? 3 : (w > MAX_W) ? MAX_W : w;
        h = (int'(h_data) < 3) ? 3 : int'(h_data);
        span = w * h;
        if (squeeze)
            hold_asks <= hold_asks + 1;
        pos = 0;
        for (int i = 0; i < n_items; i++) begin
            // now and then a grid runs on past its end with no new start
            start = (pos == 0) && ((i == 0) ? !keep_going : ($urandom_range(4) != 0));
            if (span < 1000 && $urandom_range(49) == 0) begin
                start = 1'b1;
                pos = 0;
            end
            case ($urandom_range(7))
                0: smp = SMAX;
                1: smp = SMIN;
                2: smp = SB'(int'($urandom_range(15)) - 8);
                default: smp = SB'($urandom);
            endcase
            push_sample(smp, start, 1'b0, '0, '0);
            pos = (pos + 1 == span) ? 0 : pos + 1;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int prev_w, w_pick;
        bit cont;
        warmup_plan = '{
            '{SMAX, 1'b1, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b1, SMAX, '0},
            '{SMIN, 1'b1, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b1, SMIN, '0},
            // no start: the grid wraps, center at full scale against the floor
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMAX, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b0, '0, '0},
            '{SMIN, 1'b0, 1'b1, SMIN, ERR_MAX}
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sizes below range clamp to a 3x3 grid
        load_grid_size(16'd0, 16'd2);
        foreach (warmup_plan[i])
            push_sample(warmup_plan[i].smp, warmup_plan[i].start, warmup_plan[i].pinned,
                        warmup_plan[i].want_value, warmup_plan[i].want_err);
        s_valid <= 1'b0;

        prev_w = 3;
        for (int seg = 0; seg < 3; seg++) begin
            case (seg)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 3; k++) begin
                w_pick = $urandom_range(3, 12);
                cont = (w_pick <= prev_w) && ($urandom_range(1) == 1);
                run_phase(CFG_DATA_BITS'(w_pick), CFG_DATA_BITS'($urandom_range(3, 8)),
                          $urandom_range(50, 110), cont, 1'b0);
                prev_w = w_pick;
            end
        end

        // long output stall while samples keep coming
        run_phase(16'd8, 16'd8, 150, 1'b0, 1'b1);
        // width above range clamps to the full line
        run_phase(16'hFFFF, 16'd3, 3 * MAX_W, 1'b0, 1'b0);
        run_phase(16'd5, 16'hFFFF, 150, 1'b0, 1'b0);
        // shrink both sizes mid-grid; counters saturate
        run_phase(16'd4, 16'd4, 60, 1'b1, 1'b0);

        wait_for_results();
        $display("run covered %0d samples, %0d stencil points, %0d register writes",
                 samples_in, results_seen, cfg_writes);
        $display("clamped and mid-grid sizes, full-scale swings, stalls on both sides: %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
design/jfps_pkg.sv
design/jfps_line_buf.sv
design/jacobi_four_point_stencil.sv
tb/tb.sv
